@@ design/md5_pkg.sv @@
`timescale 1ns / 1ps

package md5_pkg;

    // Standard initial chaining values
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned NUM_ROUNDS  = 64;

    typedef logic [3:0] t_word_pos;
    typedef logic [5:0] t_round;
    typedef logic [1:0] t_dig_idx;

    localparam t_word_pos LAST_WORD  = t_word_pos'(BLOCK_WORDS - 1);
    localparam t_round    LAST_ROUND = t_round'(NUM_ROUNDS - 1);
    localparam t_dig_idx  LAST_DIG   = 2'd3;

    // Round groups, selected by round[5:4]
    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;
    localparam logic [1:0] GRP_I = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    // Message word index used by a round
    function automatic t_word_pos msg_index(input t_round rnd);
        t_word_pos x;
        t_word_pos g;
        x = rnd[3:0];
        case (rnd[5:4])
            GRP_F:   g = x;
            GRP_G:   g = t_word_pos'((x << 2) + x + 4'd1);
            GRP_H:   g = t_word_pos'((x << 1) + x + 4'd5);
            GRP_I:   g = t_word_pos'((x << 3) - x);
            default: g = x;
        endcase
        return g;
    endfunction

    // Left-rotate amount of a round
    function automatic logic [4:0] rot_amount(input t_round rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'h0:    s = 5'd7;
            4'h1:    s = 5'd12;
            4'h2:    s = 5'd17;
            4'h3:    s = 5'd22;
            4'h4:    s = 5'd5;
            4'h5:    s = 5'd9;
            4'h6:    s = 5'd14;
            4'h7:    s = 5'd20;
            4'h8:    s = 5'd4;
            4'h9:    s = 5'd11;
            4'hA:    s = 5'd16;
            4'hB:    s = 5'd23;
            4'hC:    s = 5'd6;
            4'hD:    s = 5'd10;
            4'hE:    s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Additive round constants
    function automatic logic [31:0] round_const(input t_round rnd);
        logic [31:0] k;
        case (rnd)
            6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
            6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
            6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
            6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
            6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
            6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
            6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
            6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
            6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
            6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
            6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
            6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
            6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
            6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
            6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
            6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
            6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
            6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
            6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
            6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
            6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
            6'd62: k = 32'h2AD7D2BB;  default: k = 32'hEB86D391;
        endcase
        return k;
    endfunction

endpackage

@@ design/md5_if.sv @@
`timescale 1ns / 1ps

// Message word channel
interface md5_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic        new_message;

    modport source(output valid, output message_word, output new_message, input ready);
    modport sink(input valid, input message_word, input new_message, output ready);
endinterface

// Digest word channel
interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  digest_index;
    logic [31:0] digest_word;
    logic        last_of_digest;

    modport source(output valid, output digest_index, output digest_word,
                   output last_of_digest, input ready);
    modport sink(input valid, input digest_index, input digest_word,
                 input last_of_digest, output ready);
endinterface

@@ design/md5_block_compression.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Payload                                        Transactions
// i_msg     in   message_word[31:0], new_message                one per word
// o_dig     out  digest_index[1:0], digest_word[31:0],          four per block
//                last_of_digest
//
// Words 1..15 of a block are only stored. The 16th word starts the
// compression: a load step, 64 rounds of the shared round unit (one round
// per cycle), a chaining-add step, then 4 digest transactions.
// i_msg.ready is low from the 16th word until the last digest word is taken.
// Synchronous active-low reset loads the standard initial chaining value.
module md5_block_compression (
    input  logic         i_clk,
    input  logic         i_rst_n,
    md5_in_if.sink       i_msg,
    md5_out_if.source    o_dig
);
    import md5_pkg::*;

    t_state      r_state, n_state;
    t_word_pos   r_pos;
    t_round      r_round;
    t_dig_idx    r_idx;
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_km;
    logic [31:0] r_msg_mem [BLOCK_WORDS];

    logic        in_xfer;
    logic        out_xfer;
    t_word_pos   wr_pos;
    t_round      rd_round;
    logic [31:0] f_val;
    logic [31:0] t_sum;
    logic [63:0] rot_wide;
    logic [31:0] new_b;

    assign in_xfer  = i_msg.valid && i_msg.ready;
    assign out_xfer = o_dig.valid && o_dig.ready;
    assign wr_pos   = i_msg.new_message ? '0 : r_pos;

    // Round to prefetch: round 0 while loading, else the next one
    assign rd_round = (r_state == S_ROUND) ? t_round'(r_round + 6'd1) : '0;

    // Shared round unit
    always_comb begin
        case (r_round[5:4])
            GRP_F:   f_val = (r_b & r_c) | (~r_b & r_d);
            GRP_G:   f_val = (r_d & r_b) | (~r_d & r_c);
            GRP_H:   f_val = r_b ^ r_c ^ r_d;
            GRP_I:   f_val = r_c ^ (r_b | ~r_d);
            default: f_val = r_b;
        endcase
        t_sum    = f_val + r_a + r_km;
        rot_wide = {t_sum, t_sum} << rot_amount(r_round);
        new_b    = r_b + rot_wide[63:32];
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs
    always_comb begin
        n_state              = r_state;
        i_msg.ready          = 1'b0;
        o_dig.valid          = 1'b0;
        o_dig.digest_index   = r_idx;
        o_dig.digest_word    = r_chain[r_idx];
        o_dig.last_of_digest = (r_idx == LAST_DIG);
        case (r_state)
            S_IDLE: begin
                i_msg.ready = 1'b1;
                if (i_msg.valid && wr_pos == LAST_WORD) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                o_dig.valid = 1'b1;
                if (o_dig.ready && r_idx == LAST_DIG) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control counters and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_round    <= '0;
            r_idx      <= '0;
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
        end else begin
            if (in_xfer) begin
                r_pos <= (wr_pos == LAST_WORD) ? '0 : t_word_pos'(wr_pos + 4'd1);
                if (i_msg.new_message) begin
                    r_chain[0] <= IV_A;
                    r_chain[1] <= IV_B;
                    r_chain[2] <= IV_C;
                    r_chain[3] <= IV_D;
                end
            end
            if (r_state == S_ROUND) begin
                r_round <= t_round'(r_round + 6'd1);
            end
            if (r_state == S_ADD) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
            if (out_xfer) begin
                r_idx <= t_dig_idx'(r_idx + 2'd1);
            end
        end
    end

    // Block store and working registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_msg_mem[wr_pos] <= i_msg.message_word;
        end
        r_km <= round_const(rd_round) + r_msg_mem[msg_index(rd_round)];
        if (r_state == S_LOAD) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (r_state == S_ROUND) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= new_b;
        end
    end

    // Checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_msg.ready && o_dig.valid))
        else $error("input and output open at once");

    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && wr_pos == LAST_WORD) |=> (r_state == S_LOAD))
        else $error("full block did not start compression");

    a_round_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round != LAST_ROUND)
            |=> (r_state == S_ROUND && r_round == t_round'($past(r_round) + 6'd1)))
        else $error("round counter skipped");

    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_pos == '0))
        else $error("word position not cleared during compression");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_dig.last_of_digest) |=> (i_msg.ready && r_idx == '0))
        else $error("block did not return to idle after digest");

endmodule

@@ bench/tb_md5_block_compression.sv @@
`timescale 1ns / 1ps

module tb_md5_block_compression;
    import md5_pkg::*;

    localparam int RANDOM_WORDS = 270;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [31:0] word;
        logic        fresh;
    } t_word_item;

    typedef struct packed {
        t_dig_idx    idx;
        logic [31:0] word;
        logic        is_last;
    } t_digest_item;

    logic clk;
    logic rst_n;

    md5_in_if  msg_if ();
    md5_out_if dig_if ();

    md5_block_compression uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_msg   (msg_if),
        .o_dig   (dig_if)
    );

    // Additive constants and rotate amounts of the 64 rounds
    logic [31:0] rnd_k [0:63] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };
    int rot_by [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // Digest predictor state
    logic [31:0] blk_words [0:15];
    logic [31:0] chain [0:3];
    t_word_pos   fill_pos;

    t_word_item   word_queue [$];
    t_digest_item digest_fifo [$];

    int  errors;
    int  idle_cycles;
    int  words_accepted;
    bit  word_taken;
    bit  hold_off;

    // Driver state
    int burst_left;
    int gap_left;

    // Receiver pattern state
    int rdy_mode;
    int rdy_left;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // 64 rounds over the buffered block, folded into the chaining value
    task automatic run_compress();
        logic [31:0] a, b, c, d, f, t;
        logic [3:0]  g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = 4'(r);
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = 4'(5 * r + 1);
                end
                2: begin
                    f = b ^ c ^ d;
                    g = 4'(3 * r + 5);
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = 4'(7 * r);
                end
            endcase
            t = f + a + rnd_k[r] + blk_words[g];
            a = d;
            d = c;
            c = b;
            b = b + rotl(t, rot_by[(r / 16) * 4 + (r % 4)]);
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endtask

    // Take one accepted word; a full block yields four digest words
    task automatic absorb_word(input logic [31:0] w, input logic fresh);
        t_digest_item item;
        if (fresh) begin
            chain[0] = IV_A;
            chain[1] = IV_B;
            chain[2] = IV_C;
            chain[3] = IV_D;
            fill_pos = '0;
        end
        blk_words[fill_pos] = w;
        if (fill_pos != LAST_WORD) begin
            fill_pos = fill_pos + 1'b1;
        end else begin
            fill_pos = '0;
            run_compress();
            for (int k = 0; k < 4; k++) begin
                item.idx     = t_dig_idx'(k);
                item.word    = chain[k];
                item.is_last = (t_dig_idx'(k) == LAST_DIG);
                digest_fifo.push_back(item);
            end
        end
    endtask

    task automatic push_word(input logic [31:0] w, input logic fresh);
        t_word_item item;
        item.word  = w;
        item.fresh = fresh;
        word_queue.push_back(item);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Message word driver: bursts and gaps, holds an item until it is taken
    always @(negedge clk) begin
        if (!rst_n) begin
            msg_if.valid <= 1'b0;
        end else if (msg_if.valid && !word_taken) begin
            // waiting for the transaction
        end else if (gap_left > 0) begin
            gap_left--;
            msg_if.valid <= 1'b0;
        end else if (word_queue.size() > 0) begin
            msg_if.message_word <= word_queue[0].word;
            msg_if.new_message  <= word_queue[0].fresh;
            msg_if.valid        <= 1'b1;
            void'(word_queue.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end else begin
            msg_if.valid <= 1'b0;
        end
        word_taken = 1'b0;
    end

    // Digest receiver: switches between stall patterns, plus one long hold-off
    always @(negedge clk) begin
        if (!rst_n) begin
            dig_if.ready <= 1'b0;
        end else begin
            if (rdy_left <= 0) begin
                rdy_mode = $urandom_range(0, 2);
                rdy_left = $urandom_range(20, 120);
            end
            rdy_left--;
            if (hold_off)
                dig_if.ready <= 1'b0;
            else if (rdy_mode == 0)
                dig_if.ready <= 1'b1;
            else if (rdy_mode == 1)
                dig_if.ready <= 1'($urandom_range(0, 1));
            else
                dig_if.ready <= (rdy_left % 3 == 0);
        end
    end

    // Long receiver hold-off while the sender keeps offering words
    initial begin
        hold_off = 1'b0;
        while (words_accepted < 40) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Monitor: feed the predictor, compare digest transactions
    always @(posedge clk) begin
        t_digest_item want;
        bit           moved;
        moved = 1'b0;
        if (rst_n) begin
            if (msg_if.valid && msg_if.ready) begin
                absorb_word(msg_if.message_word, msg_if.new_message);
                word_taken = 1'b1;
                words_accepted++;
                moved = 1'b1;
            end
            if (dig_if.valid && dig_if.ready) begin
                moved = 1'b1;
                if (digest_fifo.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected digest transaction idx %0d word %h last %b",
                             $time, dig_if.digest_index, dig_if.digest_word,
                             dig_if.last_of_digest);
                end else begin
                    want = digest_fifo.pop_front();
                    if (dig_if.digest_index !== want.idx) begin
                        errors++;
                        $display("%0t: digest_index expected %0d actual %0d",
                                 $time, want.idx, dig_if.digest_index);
                    end
                    if (dig_if.digest_word !== want.word) begin
                        errors++;
                        $display("%0t: digest_word[%0d] expected %h actual %h",
                                 $time, want.idx, want.word, dig_if.digest_word);
                    end
                    if (dig_if.last_of_digest !== want.is_last) begin
                        errors++;
                        $display("%0t: last_of_digest[%0d] expected %b actual %b",
                                 $time, want.idx, want.is_last, dig_if.last_of_digest);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles with no transaction
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("tb_md5_block_compression: errors");
        $finish;
    end

    // Stimulus, reset and end of run
    initial begin
        int n;
        int len;
        int sel;
        rst_n               = 1'b0;
        msg_if.valid        = 1'b0;
        msg_if.message_word = '0;
        msg_if.new_message  = 1'b0;
        dig_if.ready        = 1'b0;
        errors              = 0;
        idle_cycles         = 0;
        words_accepted      = 0;
        word_taken          = 1'b0;
        burst_left          = 1;
        gap_left            = 0;
        rdy_mode            = 0;
        rdy_left            = 0;
        fill_pos            = '0;
        chain[0]            = IV_A;
        chain[1]            = IV_B;
        chain[2]            = IV_C;
        chain[3]            = IV_D;

        // Directed: padded empty message as a single block
        push_word(32'h0000_0080, 1'b1);
        for (int i = 1; i < 16; i++)
            push_word(32'h0000_0000, 1'b0);
        // Partial block of all-ones words, dropped by a new message mid-block
        for (int i = 0; i < 5; i++)
            push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);

        // Random: mostly whole messages of one to three blocks
        n = 0;
        while (n < RANDOM_WORDS) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                len = 16 * $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    push_word(rand_word(), i == 0);
            end else if (sel < 92) begin
                // broken message: partial block, odd restarts inside it
                len = $urandom_range(1, 15);
                for (int i = 0; i < len; i++)
                    push_word(rand_word(), i == 0 || $urandom_range(0, 7) == 0);
            end else begin
                // block chained onto whatever state is left
                len = 16;
                for (int i = 0; i < len; i++)
                    push_word(rand_word(), 1'b0);
            end
            n += len;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (word_queue.size() != 0 || msg_if.valid) @(posedge clk);
        while (digest_fifo.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb_md5_block_compression: clean");
        else
            $display("tb_md5_block_compression: errors");
        $finish;
    end

endmodule
